// ===== rtl/core/b64e_pkg.sv =====
// b64e_pkg: types, constants and the alphabet function of the base64 stream encoder.
// Used by the front, queue and back stages and by the top level. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package b64e_pkg;

    localparam int QUEUE_DEPTH = 2;
    localparam logic [7:0] PAD_CHAR = 8'h3D;

    typedef enum logic [1:0] {
        PHASE_FIRST  = 2'd0,
        PHASE_SECOND = 2'd1,
        PHASE_THIRD  = 2'd2
    } phase_t;

    // one accepted byte turned into up to four output characters
    typedef struct packed {
        logic [1:0]      last_idx;
        logic            eot;
        logic [3:0]      pad;
        logic [3:0][5:0] sextet;
    } job_t;

    function automatic logic [7:0] sextet_char(input logic [5:0] v);
        logic [7:0] w;
        logic [7:0] ch;
        begin
            w = {2'b00, v};
            case (v) inside
                [6'd0:6'd25]:  ch = w + 8'd65;
                [6'd26:6'd51]: ch = w + 8'd71;
                [6'd52:6'd61]: ch = w - 8'd4;
                6'd62:         ch = 8'h2B;
                default:       ch = 8'h2F;
            endcase
            return ch;
        end
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/b64e_if.sv =====
// b64e_in_if / b64e_out_if: valid/ready channels of the base64 stream encoder.
// Byte words in, character words out. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface b64e_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       final_byte;

    modport source (output valid, output data_byte, output final_byte, input ready);
    modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

interface b64e_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] code_char;
    logic       end_of_text;

    modport source (output valid, output code_char, output end_of_text, input ready);
    modport sink   (input valid, input code_char, input end_of_text, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/base64_stream_encoder_core.sv =====
// base64_stream_encoder_core: top level of the streaming base64 encoder.
// Depends on b64e_pkg, b64e_if, b64e_front, b64e_queue, b64e_back.
//
// Usage:
//   byte_stream  - sink channel, one source byte word per handshake;
//                  final_byte marks the last byte of a message.
//   char_stream  - source channel, one ASCII character word per handshake
//                  (standard alphabet or '=' pad); end_of_text marks the
//                  last character of a message.
//   Each byte yields one or two characters; the final byte yields two, three
//   or four. An accepted byte is written into the queue, and its first
//   character is then loaded into the output register. The output port sets
//   the rate: one character per cycle while the receiver is ready. Bytes are
//   taken every cycle while the two-job queue has room.
//   Reset clears the group phase, carried bits, queue and output valid flag;
//   the next byte starts a new message.
//   When the receiver stalls, the character word holds, the queue fills and
//   byte_stream.ready falls until room frees up.
`timescale 1ns / 1ps
`default_nettype none

module base64_stream_encoder_core (
    input  wire logic   clk,
    input  wire logic   rst_n,
    b64e_in_if.sink     byte_stream,
    b64e_out_if.source  char_stream
);

    b64e_pkg::job_t front_job;
    logic           front_valid;
    logic           front_ready;
    b64e_pkg::job_t head_job;
    logic           head_valid;
    logic           pop;

    b64e_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_stream (byte_stream),
        .job         (front_job),
        .job_valid   (front_valid),
        .job_ready   (front_ready)
    );

    b64e_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_job   (front_job),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .head_job   (head_job),
        .head_valid (head_valid),
        .pop        (pop)
    );

    b64e_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_job    (head_job),
        .head_valid  (head_valid),
        .pop         (pop),
        .char_stream (char_stream)
    );

endmodule

`default_nettype wire

// ===== rtl/core/b64e_front.sv =====
// b64e_front: accepts byte words, tracks group phase and carried bits, builds jobs.
// Depends on b64e_pkg and b64e_in_if.
`timescale 1ns / 1ps
`default_nettype none

module b64e_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    b64e_in_if.sink            byte_stream,
    output b64e_pkg::job_t     job,
    output logic               job_valid,
    input  wire logic          job_ready
);

    b64e_pkg::phase_t phase_reg, phase_next;
    logic [3:0]       carry_reg, carry_next;
    logic             accept;
    logic [7:0]       b;
    logic             fin;

    assign byte_stream.ready = job_ready;
    assign job_valid         = byte_stream.valid;
    assign accept            = byte_stream.valid && job_ready;
    assign b                 = byte_stream.data_byte;
    assign fin               = byte_stream.final_byte;

    always_comb
    begin
        job        = '0;
        phase_next = phase_reg;
        carry_next = carry_reg;
        case (phase_reg)
            b64e_pkg::PHASE_SECOND:
            begin
                job.sextet[0] = {carry_reg[1:0], b[7:4]};
                if (fin)
                begin
                    job.sextet[1] = {b[3:0], 2'b00};
                    job.pad[2]    = 1'b1;
                    job.last_idx  = 2'd2;
                    job.eot       = 1'b1;
                end
                phase_next = b64e_pkg::PHASE_THIRD;
                carry_next = b[3:0];
            end
            b64e_pkg::PHASE_THIRD:
            begin
                job.sextet[0] = {carry_reg, b[7:6]};
                job.sextet[1] = b[5:0];
                job.last_idx  = 2'd1;
                job.eot       = fin;
                phase_next    = b64e_pkg::PHASE_FIRST;
                carry_next    = 4'd0;
            end
            default:
            begin
                job.sextet[0] = b[7:2];
                if (fin)
                begin
                    job.sextet[1] = {b[1:0], 4'b0000};
                    job.pad[2]    = 1'b1;
                    job.pad[3]    = 1'b1;
                    job.last_idx  = 2'd3;
                    job.eot       = 1'b1;
                end
                phase_next = b64e_pkg::PHASE_SECOND;
                carry_next = {2'b00, b[1:0]};
            end
        endcase
        if (fin)
        begin
            phase_next = b64e_pkg::PHASE_FIRST;
            carry_next = 4'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= b64e_pkg::PHASE_FIRST;
            carry_reg <= 4'd0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            carry_reg <= carry_next;
        end
    end

`ifndef SYNTHESIS
    // carry only nonzero mid-group
    a_carry_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == b64e_pkg::PHASE_FIRST) |-> (carry_reg == 4'd0))
        else $error("carry bits set at group start");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/b64e_queue.sv =====
// b64e_queue: two-entry job queue between front and back stages.
// Depends on b64e_pkg.
`timescale 1ns / 1ps
`default_nettype none

module b64e_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire b64e_pkg::job_t  push_job,
    input  wire logic            push_valid,
    output logic                 push_ready,
    output b64e_pkg::job_t       head_job,
    output logic                 head_valid,
    input  wire logic            pop
);

    b64e_pkg::job_t entry_reg [b64e_pkg::QUEUE_DEPTH];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push;
    logic       do_pop;

    assign push_ready = (count_reg != 2'(b64e_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != 2'd0);
    assign head_job   = entry_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 2'(b64e_pkg::QUEUE_DEPTH))
        else $error("queue count overflow");
    a_ptr_count: assert property (@(posedge clk) disable iff (!rst_n)
        ((count_reg == 2'd0) || (count_reg == 2'(b64e_pkg::QUEUE_DEPTH)))
        |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree with count");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/b64e_back.sv =====
// b64e_back: walks the head job into the output register, one character a cycle unless stalled.
// Depends on b64e_pkg and b64e_out_if.
`timescale 1ns / 1ps
`default_nettype none

module b64e_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire b64e_pkg::job_t  head_job,
    input  wire logic            head_valid,
    output logic                 pop,
    b64e_out_if.source           char_stream
);

    logic [1:0] idx_reg, idx_next;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] char_reg, char_next;
    logic       eot_reg, eot_next;
    logic       load;
    logic       at_last;

    assign load    = head_valid && (!out_valid_reg || char_stream.ready);
    assign at_last = (idx_reg == head_job.last_idx);
    assign pop     = load && at_last;

    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (char_stream.ready)
        begin
            out_valid_next = 1'b0;
        end
        char_next = head_job.pad[idx_reg] ? b64e_pkg::PAD_CHAR
                                          : b64e_pkg::sextet_char(head_job.sextet[idx_reg]);
        eot_next  = head_job.eot && at_last;
        if (load)
        begin
            out_valid_next = 1'b1;
            idx_next       = at_last ? 2'd0 : idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            char_reg <= char_next;
            eot_reg  <= eot_next;
        end
    end

    assign char_stream.valid       = out_valid_reg;
    assign char_stream.code_char   = char_reg;
    assign char_stream.end_of_text = eot_reg;

`ifndef SYNTHESIS
    a_mid_job_head: assert property (@(posedge clk) disable iff (!rst_n)
        (idx_reg != 2'd0) |-> head_valid)
        else $error("job index advanced with empty queue");
    a_idx_step: assert property (@(posedge clk) disable iff (!rst_n)
        (load && !at_last) |=> (idx_reg == $past(idx_reg) + 2'd1))
        else $error("character index did not advance");
`endif

endmodule

`default_nettype wire

// ===== bench/tb_base64_stream_encoder_core.sv =====
// tb_base64_stream_encoder_core: self-checking bench for the streaming base64 encoder.
// Drives byte words through a directed table and then random messages under idle and stall.
// Depends on b64e_pkg, b64e_if and base64_stream_encoder_core.
`timescale 1ns / 1ps

module tb_base64_stream_encoder_core;

    localparam logic [511:0] ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
    localparam logic [7:0] EQ_CHAR = 8'h3D;
    localparam int DRAIN_CYCLES = 20;
    localparam int PHASE_ITEMS = 106;

    typedef struct packed {
        logic [7:0] ch;
        logic       eot;
    } char_word_t;

    // n = 0: row is checked against the encoder model only
    typedef struct packed {
        logic [7:0]  b;
        logic        fin;
        logic [2:0]  n;
        logic [31:0] chars;
    } dir_row_t;

    localparam int NUM_ROWS = 24;
    localparam dir_row_t DIRECTED [NUM_ROWS] = '{
        '{8'h00, 1'b1, 3'd4, "AA=="},
        '{8'hFF, 1'b1, 3'd4, "/w=="},
        '{8'h00, 1'b0, 3'd0, 32'd0},
        '{8'h00, 1'b1, 3'd3, "AA="},
        '{8'hFF, 1'b0, 3'd0, 32'd0},
        '{8'hFF, 1'b1, 3'd3, "/8="},
        '{8'h00, 1'b0, 3'd0, 32'd0},
        '{8'h00, 1'b0, 3'd0, 32'd0},
        '{8'h00, 1'b1, 3'd2, "AA"},
        '{8'hFF, 1'b0, 3'd0, 32'd0},
        '{8'hFF, 1'b0, 3'd0, 32'd0},
        '{8'hFF, 1'b1, 3'd2, "//"},
        '{8'h4D, 1'b0, 3'd0, 32'd0},
        '{8'h61, 1'b0, 3'd0, 32'd0},
        '{8'h6E, 1'b1, 3'd2, "Fu"},
        '{8'h4D, 1'b1, 3'd4, "TQ=="},
        '{8'h4D, 1'b0, 3'd0, 32'd0},
        '{8'h61, 1'b1, 3'd3, "WE="},
        '{8'h80, 1'b0, 3'd0, 32'd0},
        '{8'h20, 1'b0, 3'd0, 32'd0},
        '{8'h55, 1'b0, 3'd0, 32'd0},
        '{8'hAA, 1'b0, 3'd0, 32'd0},
        '{8'h01, 1'b0, 3'd0, 32'd0},
        '{8'hFE, 1'b1, 3'd0, 32'd0}
    };

    logic clk;
    logic rst_n;

    b64e_in_if  byte_if ();
    b64e_out_if char_if ();

    base64_stream_encoder_core uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_stream (byte_if),
        .char_stream (char_if)
    );

    logic [3:0]         carry_q;
    b64e_pkg::phase_t   phase_q;
    char_word_t         pending_chars [$];
    int                 idle_pct;
    int                 stall_pct;
    int                 fail_count;
    int                 bytes_sent;
    int                 chars_checked;
    int                 messages_sent;

    initial begin
        clk = 1'b0;
    end

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic logic [7:0] alpha_char(input logic [5:0] v);
        return ALPHABET[(63 - int'(v)) * 8 +: 8];
    endfunction

    // encoder model: returns the character words one byte produces
    function automatic int encode_byte(input logic [7:0] b, input logic fin,
                                       output logic [3:0][8:0] words);
        int n;
        begin
            words = '0;
            case (phase_q)
                b64e_pkg::PHASE_SECOND:
                begin
                    words[0] = {alpha_char({carry_q[1:0], b[7:4]}), 1'b0};
                    if (fin)
                    begin
                        words[1] = {alpha_char({b[3:0], 2'b00}), 1'b0};
                        words[2] = {EQ_CHAR, 1'b1};
                        n = 3;
                    end
                    else
                    begin
                        carry_q = b[3:0];
                        phase_q = b64e_pkg::PHASE_THIRD;
                        n = 1;
                    end
                end
                b64e_pkg::PHASE_THIRD:
                begin
                    words[0] = {alpha_char({carry_q, b[7:6]}), 1'b0};
                    words[1] = {alpha_char(b[5:0]), fin};
                    carry_q = '0;
                    phase_q = b64e_pkg::PHASE_FIRST;
                    n = 2;
                end
                default:
                begin
                    words[0] = {alpha_char(b[7:2]), 1'b0};
                    if (fin)
                    begin
                        words[1] = {alpha_char({b[1:0], 4'b0000}), 1'b0};
                        words[2] = {EQ_CHAR, 1'b0};
                        words[3] = {EQ_CHAR, 1'b1};
                        n = 4;
                    end
                    else
                    begin
                        carry_q = {2'b00, b[1:0]};
                        phase_q = b64e_pkg::PHASE_SECOND;
                        n = 1;
                    end
                end
            endcase
            if (fin)
            begin
                carry_q = '0;
                phase_q = b64e_pkg::PHASE_FIRST;
            end
            return n;
        end
    endfunction

    // n_typed > 0: push the typed characters instead of the model's
    task automatic send_byte(input logic [7:0] b, input logic fin,
                             input int n_typed, input logic [31:0] typed);
        logic [3:0][8:0] words;
        int n;
        char_word_t w;
        begin
            while ($urandom_range(0, 99) < idle_pct)
            begin
                byte_if.valid <= 1'b0;
                @(posedge clk);
            end
            byte_if.valid      <= 1'b1;
            byte_if.data_byte  <= b;
            byte_if.final_byte <= fin;
            do
                @(posedge clk);
            while (!byte_if.ready);
            n = encode_byte(b, fin, words);
            if (n_typed > 0)
            begin
                for (int k = 0; k < n_typed; k++)
                begin
                    w.ch  = typed[(n_typed - 1 - k) * 8 +: 8];
                    w.eot = fin && (k == n_typed - 1);
                    pending_chars.push_back(w);
                end
            end
            else
            begin
                for (int k = 0; k < n; k++)
                    pending_chars.push_back(words[k]);
            end
            bytes_sent++;
            if (fin)
                messages_sent++;
        end
    endtask

    task automatic send_message(input int len);
        logic [7:0] b;
        begin
            for (int i = 0; i < len; i++)
            begin
                case ($urandom_range(0, 9))
                    0:       b = 8'h00;
                    1:       b = 8'hFF;
                    default: b = 8'($urandom_range(0, 255));
                endcase
                send_byte(b, i == len - 1, 0, 32'd0);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            char_if.ready <= 1'b0;
        else
            char_if.ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && char_if.valid && char_if.ready)
        begin
            if (pending_chars.size() == 0)
            begin
                $error("code_char: expected none, actual %h", char_if.code_char);
                fail_count++;
            end
            else
            begin
                if (char_if.code_char !== pending_chars[0].ch)
                begin
                    $error("code_char: expected %h, actual %h",
                           pending_chars[0].ch, char_if.code_char);
                    fail_count++;
                end
                if (char_if.end_of_text !== pending_chars[0].eot)
                begin
                    $error("end_of_text: expected %b, actual %b",
                           pending_chars[0].eot, char_if.end_of_text);
                    fail_count++;
                end
                void'(pending_chars.pop_front());
                chars_checked++;
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        int phase_start;
        int len;
        rst_n              = 1'b0;
        byte_if.valid      = 1'b0;
        byte_if.data_byte  = '0;
        byte_if.final_byte = 1'b0;
        carry_q            = '0;
        phase_q            = b64e_pkg::PHASE_FIRST;
        idle_pct           = 0;
        stall_pct          = 0;
        fail_count         = 0;
        bytes_sent         = 0;
        chars_checked      = 0;
        messages_sent      = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < NUM_ROWS; r++)
            send_byte(DIRECTED[r].b, DIRECTED[r].fin, int'(DIRECTED[r].n), DIRECTED[r].chars);

        for (int p = 0; p < 4; p++)
        begin
            case (p)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 64; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 64; end
                default: begin idle_pct = 16; stall_pct = 16; end
            endcase
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_ITEMS)
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
                                                  : $urandom_range(1, 6);
                send_message(len);
            end
        end
        byte_if.valid <= 1'b0;

        while (pending_chars.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_chars.size() != 0)
        begin
            $error("code_char: %0d words never arrived", pending_chars.size());
            fail_count++;
        end

        $display("Encoded %0d bytes in %0d messages, %0d characters checked,",
                 bytes_sent, messages_sent, chars_checked);
        $display("over free-running, sender-idle, receiver-stall and mixed traffic.");
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
